### rtl/core/tssam_pkg.sv
`default_nettype none

package tssam_pkg;

    localparam logic [7:0] TS_SYNC_MARK       = 8'h47;
    localparam logic [7:0] DEFAULT_PKT_LEN    = 8'd188;
    localparam logic [3:0] DEFAULT_ACQUIRE    = 4'd5;

    localparam int         CFG_IDX_W          = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACQUIRE_COUNT = 1'b1;
    localparam int         CFG_DATA_W         = 8;

    typedef struct packed {
        logic        in_sync;
        logic [3:0]  good_run;
        logic        loss_pending;
        logic [31:0] position;
    } chan_state_t;

    typedef struct packed {
        logic        packet_valid;
        logic        sync_loss_event;
        logic        sync_byte_error;
        logic [31:0] byte_position;
        logic        position_carry;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/tssam_if.sv
`default_nettype none

interface tssam_in_if;
    logic       valid;
    logic       ready;
    logic       channel;
    logic [7:0] first_byte;

    modport source (output valid, output channel, output first_byte, input ready);
    modport sink   (input valid, input channel, input first_byte, output ready);
endinterface

interface tssam_out_if;
    logic        valid;
    logic        ready;
    logic        packet_valid;
    logic        sync_loss_event;
    logic        sync_byte_error;
    logic [31:0] byte_position;
    logic        position_carry;

    modport source (output valid, output packet_valid, output sync_loss_event,
                    output sync_byte_error, output byte_position,
                    output position_carry, input ready);
    modport sink   (input valid, input packet_valid, input sync_loss_event,
                    input sync_byte_error, input byte_position,
                    input position_carry, output ready);
endinterface

`default_nettype wire

### rtl/core/tssam_state_ram.sv
`default_nettype none

module tssam_state_ram
    import tssam_pkg::*;
#(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output chan_state_t            rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire chan_state_t       wr_data
);

    chan_state_t             mem [DEPTH];
    chan_state_t             rd_raw_reg;
    logic [DEPTH-1:0]        vld_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as the all-zero state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

### rtl/core/tssam_update.sv
`default_nettype none

module tssam_update
    import tssam_pkg::*;
(
    input  wire chan_state_t  cur_state,
    input  wire logic [7:0]   first_byte,
    input  wire logic [7:0]   packet_length,
    input  wire logic [3:0]   acquire_count,
    output chan_state_t       new_state,
    output result_t           res
);

    logic [32:0] pos_sum;
    logic        carry;
    logic [31:0] new_pos;
    logic [4:0]  run;
    logic        is_sync;

    // A wrap adds one extra byte: len - (MAX - pos) equals pos + len + 1 mod 2^32.
    assign pos_sum = {1'b0, cur_state.position} + 33'(packet_length);
    assign carry   = pos_sum[32];
    assign new_pos = pos_sum[31:0] + 32'(carry);
    assign run     = {1'b0, cur_state.good_run} + 5'd1;
    assign is_sync = (first_byte == TS_SYNC_MARK);

    always_comb
    begin
        new_state          = cur_state;
        new_state.position = new_pos;
        res                = '0;
        res.byte_position  = new_pos;
        res.position_carry = carry;
        if (!cur_state.in_sync)
        begin
            if (is_sync)
            begin
                if (run >= {1'b0, acquire_count})
                begin
                    new_state.in_sync  = 1'b1;
                    new_state.good_run = 4'd0;
                    if (cur_state.loss_pending)
                    begin
                        res.sync_loss_event    = 1'b1;
                        new_state.loss_pending = 1'b0;
                    end
                end
                else
                begin
                    new_state.good_run = run[3:0];
                end
            end
            else
            begin
                res.sync_byte_error = cur_state.loss_pending;
                new_state.good_run  = 4'd0;
            end
        end
        else
        begin
            if (is_sync)
            begin
                res.packet_valid = 1'b1;
            end
            else
            begin
                new_state.loss_pending = 1'b1;
                new_state.in_sync      = 1'b0;
                new_state.good_run     = 4'd0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ts_sync_acquire_monitor.sv
// Transport-stream sync acquisition and loss monitor, one state entry per channel.
// Item channel: one transaction per packet carries the channel number and the
// packet's first byte. Result channel: one transaction per item whose channel
// is below CHANNELS, with validity, sync-loss and sync-byte-error flags, the
// channel byte position after the packet and its wrap carry. Items for a
// channel at or above CHANNELS are taken and dropped without a result.
// The configuration port writes packet_length (index 0) and acquire_count
// (index 1); write it only while no transaction is in flight.
// Pipeline: an accepted item is registered in the read stage and its result in
// the output register. Throughput: one item per cycle while the receiver does
// not stall, set by the single read-modify-write pass over the channel state
// memory; a state written to the same channel during a read is forwarded.
// Reset clears all channel state to zero at once through per-entry valid
// bits and loads the register defaults (188 bytes, 5 sync bytes).
// When the receiver stalls, the result is held in the output register, one
// further item waits in the read stage, and then the item channel stalls.
`default_nettype none

module ts_sync_acquire_monitor
    import tssam_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    tssam_in_if.sink                   item,
    tssam_out_if.source                result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]       packet_length_reg;
    logic [3:0]       acquire_count_reg;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [IDX_W-1:0] s1_chan_reg;
    logic [7:0]       s1_byte_reg;
    logic             fwd_hit_reg;
    chan_state_t      fwd_state_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_res_reg;

    logic             in_range;
    logic             accept;
    logic             take;
    logic             s1_adv;
    logic [IDX_W-1:0] in_idx;

    chan_state_t      ram_rd_data;
    chan_state_t      cur_state;
    chan_state_t      upd_state;
    result_t          upd_res;

    assign in_idx     = IDX_W'(item.channel);
    assign in_range   = (CHANNELS > 1) || (item.channel == 1'b0);
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign accept     = item.valid && item.ready;
    assign take       = accept && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_length_reg <= DEFAULT_PKT_LEN;
            acquire_count_reg <= DEFAULT_ACQUIRE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PACKET_LENGTH: packet_length_reg <= cfg_wdata[7:0];
                CFG_ACQUIRE_COUNT: acquire_count_reg <= cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    tssam_state_ram #(
        .DEPTH  (CHANNELS),
        .ADDR_W (IDX_W)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_chan_reg),
        .wr_data (upd_state)
    );

    // The memory read of a new item races the write of the item ahead of it.
    assign cur_state = fwd_hit_reg ? fwd_state_reg : ram_rd_data;

    tssam_update u_update (
        .cur_state     (cur_state),
        .first_byte    (s1_byte_reg),
        .packet_length (packet_length_reg),
        .acquire_count (acquire_count_reg),
        .new_state     (upd_state),
        .res           (upd_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                fwd_hit_reg <= s1_adv && (s1_chan_reg == in_idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_chan_reg   <= in_idx;
            s1_byte_reg   <= item.first_byte;
            fwd_state_reg <= upd_state;
        end
        if (s1_adv)
        begin
            out_res_reg <= upd_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.packet_valid    = out_res_reg.packet_valid;
    assign result.sync_loss_event = out_res_reg.sync_loss_event;
    assign result.sync_byte_error = out_res_reg.sync_byte_error;
    assign result.byte_position   = out_res_reg.byte_position;
    assign result.position_carry  = out_res_reg.position_carry;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("item taken while both stages are full and stalled");

    a_forward_on_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_adv && (s1_chan_reg == in_idx)) |=> fwd_hit_reg)
        else $error("same-channel back-to-back item missed forwarding");

    a_carry_small_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.position_carry)
            |-> (result.byte_position <= 32'(packet_length_reg)))
        else $error("wrapped position exceeds packet length");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.packet_valid && result.sync_loss_event))
        else $error("valid packet reported together with sync regain");
`endif

endmodule

`default_nettype wire
